/* hw/rtl/cafn_pkg.sv */
// Shared types and constants for the color attribute fetch and normalize block.
// Holds the item structs, configuration layout and normalization constants.
// No dependencies.
`default_nettype none

package cafn_pkg;

    localparam int VERTEX_INDEX_W   = 24;
    localparam int RAW_W            = 64;
    localparam int OFFSET_W         = 33;
    localparam int COLOR_W          = 16;
    localparam int SPAN_W           = 9;
    localparam int CFG_INDEX_W      = 2;
    localparam int CFG_DATA_W       = 8;

    localparam logic [COLOR_W-1:0] FULL_SCALE = 16'hFFFF;

    // Type maxima of the 32-bit integer types, used in the Mersenne reduction.
    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [32:0] U32_MAX = 33'h0_FFFF_FFFF;

    // Rounding bias (max - 1) / 2 for the 32-bit integer types.
    localparam logic [47:0] S32_BIAS = 48'h0000_3FFF_FFFF;
    localparam logic [48:0] U32_BIAS = 49'h0_0000_7FFF_FFFF;

    // Signed byte: 65535 / 127 = 516 + 3 / 127, rounding steps at these values.
    localparam logic [6:0] S8_STEP_A = 7'd22;
    localparam logic [6:0] S8_STEP_B = 7'd64;
    localparam logic [6:0] S8_STEP_C = 7'd106;

    // Float exponent limits: at or above ONE the value saturates, below MIN it is 0.
    localparam logic [7:0]  F32_EXP_ONE = 8'd127;
    localparam logic [7:0]  F32_EXP_MIN = 8'd109;
    localparam logic [7:0]  F32_EXP_TOP = 8'd126;
    localparam logic [7:0]  F32_EXP_NAN = 8'hFF;
    localparam logic [10:0] F64_EXP_ONE = 11'd1023;
    localparam logic [10:0] F64_EXP_MIN = 11'd1005;
    localparam logic [10:0] F64_EXP_TOP = 11'd1022;
    localparam logic [10:0] F64_EXP_NAN = 11'h7FF;

    typedef enum logic [2:0] {
        ELEM_S8  = 3'd0,
        ELEM_U8  = 3'd1,
        ELEM_S16 = 3'd2,
        ELEM_U16 = 3'd3,
        ELEM_S32 = 3'd4,
        ELEM_U32 = 3'd5,
        ELEM_F32 = 3'd6,
        ELEM_F64 = 3'd7
    } t_elem_type;

    localparam logic [CFG_INDEX_W-1:0] CFG_ELEMENT_TYPE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMPONENT_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ELEMENT_STRIDE  = 2'd2;

    localparam logic [2:0] COUNT_RGB  = 3'd3;
    localparam logic [2:0] COUNT_RGBA = 3'd4;

    localparam t_elem_type  RST_ELEMENT_TYPE    = ELEM_U8;
    localparam logic [2:0]  RST_COMPONENT_COUNT = COUNT_RGBA;
    localparam logic [7:0]  RST_ELEMENT_STRIDE  = 8'd0;

    typedef struct packed {
        t_elem_type  element_type;
        logic [2:0]  component_count;
        logic [7:0]  element_stride;
    } t_cfg;

    typedef struct packed {
        logic [VERTEX_INDEX_W-1:0] vertex_index;
        logic [RAW_W-1:0]          raw_red;
        logic [RAW_W-1:0]          raw_green;
        logic [RAW_W-1:0]          raw_blue;
        logic [RAW_W-1:0]          raw_alpha;
    } t_in_item;

    typedef struct packed {
        logic [OFFSET_W-1:0] element_offset;
        logic [COLOR_W-1:0]  red_out;
        logic [COLOR_W-1:0]  green_out;
        logic [COLOR_W-1:0]  blue_out;
        logic [COLOR_W-1:0]  alpha_out;
    } t_out_item;

endpackage

`default_nettype wire

/* hw/rtl/cafn_cfg.sv */
// Configuration register file for the color attribute fetch and normalize block.
// Depends on cafn_pkg for the register layout and reset values.
`default_nettype none

module cafn_cfg
    import cafn_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_cfg                        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Writes are always taken; a write beyond the register list is dropped.
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ELEMENT_TYPE:    n_cfg.element_type    = t_elem_type'(i_cfg_data[2:0]);
                CFG_COMPONENT_COUNT: n_cfg.component_count = i_cfg_data[2:0];
                CFG_ELEMENT_STRIDE:  n_cfg.element_stride  = i_cfg_data;
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.element_type    <= RST_ELEMENT_TYPE;
            r_cfg.component_count <= RST_COMPONENT_COUNT;
            r_cfg.element_stride  <= RST_ELEMENT_STRIDE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* hw/rtl/cafn_norm.sv */
// Normalizes one raw component word to a 16-bit unsigned fraction.
// Combinational; depends on cafn_pkg for element type codes and constants.
`default_nettype none

module cafn_norm
    import cafn_pkg::*;
(
    input  wire t_elem_type          i_elem_type,
    input  wire logic [RAW_W-1:0]    i_raw,
    output logic [COLOR_W-1:0]       o_value
);

    // Signed byte: 516 * x plus a rounding step of 0 to 3.
    logic [6:0]  s8_x;
    logic [1:0]  s8_step;
    logic [15:0] s8_val;

    // 32-bit integers: y = x * 65535 + bias, then y / (2^n - 1) by end-around fold.
    logic [30:0] s32_x;
    logic [47:0] s32_y;
    logic [16:0] s32_h;
    logic [31:0] s32_fold;
    logic [16:0] s32_q;
    logic [31:0] u32_x;
    logic [48:0] u32_y;
    logic [16:0] u32_h;
    logic [32:0] u32_fold;
    logic [16:0] u32_q;

    // Floats: mantissa * 65535, keep the top 17 bits, shift and round by half.
    logic [7:0]  f32_ex;
    logic        f32_nan;
    logic [23:0] f32_m;
    logic [39:0] f32_p;
    logic [4:0]  f32_sh;
    logic [16:0] f32_t;
    logic [17:0] f32_r;
    logic [15:0] f32_val;
    logic [10:0] f64_ex;
    logic        f64_nan;
    logic [52:0] f64_m;
    logic [68:0] f64_p;
    logic [4:0]  f64_sh;
    logic [16:0] f64_t;
    logic [17:0] f64_r;
    logic [15:0] f64_val;

    always_comb begin
        s8_x    = i_raw[6:0];
        s8_step = 2'((s8_x >= S8_STEP_A) ? 1 : 0) + 2'((s8_x >= S8_STEP_B) ? 1 : 0)
                + 2'((s8_x >= S8_STEP_C) ? 1 : 0);
        s8_val  = {s8_x, 9'd0} + {7'd0, s8_x, 2'd0} + {14'd0, s8_step};

        s32_x    = i_raw[30:0];
        s32_y    = {1'b0, s32_x, 16'd0} - {17'd0, s32_x} + S32_BIAS;
        s32_h    = s32_y[47:31];
        s32_fold = {15'd0, s32_h} + {1'b0, s32_y[30:0]};
        s32_q    = s32_h + 17'((s32_fold >= S32_MAX) ? 1 : 0);

        u32_x    = i_raw[31:0];
        u32_y    = {1'b0, u32_x, 16'd0} - {17'd0, u32_x} + U32_BIAS;
        u32_h    = u32_y[48:32];
        u32_fold = {16'd0, u32_h} + {1'b0, u32_y[31:0]};
        u32_q    = u32_h + 17'((u32_fold >= U32_MAX) ? 1 : 0);

        f32_ex  = i_raw[30:23];
        f32_nan = (f32_ex == F32_EXP_NAN) && (i_raw[22:0] != 23'd0);
        f32_m   = {1'b1, i_raw[22:0]};
        f32_p   = {f32_m, 16'd0} - {16'd0, f32_m};
        f32_sh  = 5'(F32_EXP_TOP - f32_ex);
        f32_t   = f32_p[39:23] >> f32_sh;
        f32_r   = {1'b0, f32_t} + 18'd1;
        if (f32_nan || i_raw[31] || (f32_ex < F32_EXP_MIN)) begin
            f32_val = '0;
        end else if (f32_ex >= F32_EXP_ONE) begin
            f32_val = FULL_SCALE;
        end else begin
            f32_val = f32_r[16:1];
        end

        f64_ex  = i_raw[62:52];
        f64_nan = (f64_ex == F64_EXP_NAN) && (i_raw[51:0] != 52'd0);
        f64_m   = {1'b1, i_raw[51:0]};
        f64_p   = {f64_m, 16'd0} - {16'd0, f64_m};
        f64_sh  = 5'(F64_EXP_TOP - f64_ex);
        f64_t   = f64_p[68:52] >> f64_sh;
        f64_r   = {1'b0, f64_t} + 18'd1;
        if (f64_nan || i_raw[63] || (f64_ex < F64_EXP_MIN)) begin
            f64_val = '0;
        end else if (f64_ex >= F64_EXP_ONE) begin
            f64_val = FULL_SCALE;
        end else begin
            f64_val = f64_r[16:1];
        end

        case (i_elem_type)
            ELEM_S8:  o_value = i_raw[7] ? '0 : s8_val;
            ELEM_U8:  o_value = {i_raw[7:0], i_raw[7:0]};
            // 65535 / 32767 = 2 + 1 / 32767, so the upper half rounds up by one.
            ELEM_S16: o_value = i_raw[15] ? '0 : {i_raw[14:0], i_raw[14]};
            ELEM_U16: o_value = i_raw[15:0];
            ELEM_S32: o_value = i_raw[31] ? '0 : s32_q[15:0];
            ELEM_U32: o_value = u32_q[15:0];
            ELEM_F32: o_value = f32_val;
            ELEM_F64: o_value = f64_val;
            default:  o_value = '0;
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/color_attribute_fetch_normalize.sv */
// Color attribute fetch and normalize: element offset and four normalized colors.
// Throughput is one transaction per cycle while the output is not stalled.
// An input register feeds the normalizers, whose results land in an output register.
// Synchronous active-low reset empties both stages and loads the register defaults.
// Depends on cafn_pkg, cafn_cfg and cafn_norm.
`default_nettype none

module color_attribute_fetch_normalize
    import cafn_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire t_in_item               i_in_data,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output t_out_item                   o_out_data,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg      cfg;
    logic      r_s1_valid;
    t_in_item  r_s1_data;
    logic      r_out_valid;
    t_out_item r_out_data;
    t_out_item n_out_data;
    logic      adv_out;
    logic      adv_s1;
    logic      in_accept;
    logic [SPAN_W-1:0]  span;
    logic [COLOR_W-1:0] red_n;
    logic [COLOR_W-1:0] green_n;
    logic [COLOR_W-1:0] blue_n;
    logic [COLOR_W-1:0] alpha_n;
    logic               has_color;

    cafn_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    cafn_norm u_norm_red (
        .i_elem_type (cfg.element_type),
        .i_raw       (r_s1_data.raw_red),
        .o_value     (red_n)
    );

    cafn_norm u_norm_green (
        .i_elem_type (cfg.element_type),
        .i_raw       (r_s1_data.raw_green),
        .o_value     (green_n)
    );

    cafn_norm u_norm_blue (
        .i_elem_type (cfg.element_type),
        .i_raw       (r_s1_data.raw_blue),
        .o_value     (blue_n)
    );

    cafn_norm u_norm_alpha (
        .i_elem_type (cfg.element_type),
        .i_raw       (r_s1_data.raw_alpha),
        .o_value     (alpha_n)
    );

    // The output register frees when empty or taken; the input stage frees when
    // empty or moving into the output register.
    assign adv_out    = !r_out_valid || !i_out_stall;
    assign adv_s1     = !r_s1_valid || adv_out;
    assign o_in_stall = !adv_s1;
    assign in_accept  = i_in_valid && adv_s1;

    always_comb begin
        span      = {6'd0, cfg.component_count} + {1'b0, cfg.element_stride};
        has_color = (cfg.component_count == COUNT_RGB) || (cfg.component_count == COUNT_RGBA);
        n_out_data.element_offset = {9'd0, r_s1_data.vertex_index} * {24'd0, span};
        if (has_color) begin
            n_out_data.red_out   = red_n;
            n_out_data.green_out = green_n;
            n_out_data.blue_out  = blue_n;
            n_out_data.alpha_out = (cfg.component_count == COUNT_RGBA) ? alpha_n : FULL_SCALE;
        end else begin
            n_out_data.red_out   = '0;
            n_out_data.green_out = '0;
            n_out_data.blue_out  = '0;
            n_out_data.alpha_out = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv_s1) begin
                r_s1_valid <= i_in_valid;
            end
            if (adv_out) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_data <= i_in_data;
        end
        if (adv_out && r_s1_valid) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Upstream is held off only when both stages are occupied.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid))
        else $error("input stalled while a stage is free");

    // A waiting input-stage item is neither lost nor altered.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !adv_out) |=> (r_s1_valid && $stable(r_s1_data)))
        else $error("input stage item dropped or changed while blocked");

    // A result taken with nothing behind it leaves the output empty.
    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_stall && !r_s1_valid) |=> !r_out_valid)
        else $error("result repeated after transaction");

    // A result appears only from an item that was in the input stage.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !r_s1_valid) |=> !r_out_valid)
        else $error("result invented without an input item");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for color_attribute_fetch_normalize.
// Predicts offsets and normalized colors per vertex and checks every result in order.
// Depends on cafn_pkg and the color_attribute_fetch_normalize RTL.
`default_nettype none

module tb_top
    import cafn_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          PIPE_LATENCY  = 2;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int          RANDOM_PHASES = 12;
    localparam int          PHASE_VERTS   = 160;
    localparam int          MAX_REPORTS   = 40;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    localparam logic [63:0] S8_TOP  = 64'd127;
    localparam logic [63:0] U8_TOP  = 64'd255;
    localparam logic [63:0] S16_TOP = 64'd32767;
    localparam logic [63:0] U16_TOP = 64'd65535;
    localparam logic [63:0] S32_TOP = 64'd2147483647;
    localparam logic [63:0] U32_TOP = 64'd4294967295;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_item    in_data;
    logic        out_valid;
    logic        out_stall;
    t_out_item   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Shadow of the block's format registers, updated on each register transaction.
    t_cfg        fmt;
    t_out_item   expected_colors[$];

    bit          idle_on = 1'b1;
    int          stall_left = 0;
    int          errors = 0;
    int          vertices_sent = 0;
    int          results_seen = 0;
    int          reg_writes = 0;
    int unsigned cycle_count = 0;

    color_attribute_fetch_normalize uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("Timeout after %0d cycles, %0d results still expected",
                 cycle_count, expected_colors.size());
        $display("Verification failed");
        $finish;
    end

    // ---------------------------------------------------------------- prediction

    function automatic logic [15:0] unit_from_int(input logic [63:0] x, input logic [63:0] top);
        logic [63:0] q;
        q = (2 * x * 65535 + top) / (2 * top);
        return q[15:0];
    endfunction

    function automatic logic [15:0] unit_from_f32(input logic [31:0] b);
        logic [7:0]  ex;
        logic [63:0] prod;
        int          k;
        ex = b[30:23];
        if (ex == 8'hFF && b[22:0] != 23'd0) return 16'd0;
        if (b[31]) return 16'd0;
        if (ex >= 8'd127) return FULL_SCALE;
        if (ex == 8'd0) return 16'd0;
        k = 150 - int'(ex);
        if (k > 41) return 16'd0;
        prod = {40'd0, 1'b1, b[22:0]} * 64'd65535;
        prod = (prod + (64'd1 << (k - 1))) >> k;
        return prod[15:0];
    endfunction

    function automatic logic [15:0] unit_from_f64(input logic [63:0] b);
        logic [10:0]  ex;
        logic [127:0] prod;
        int           k;
        ex = b[62:52];
        if (ex == 11'h7FF && b[51:0] != 52'd0) return 16'd0;
        if (b[63]) return 16'd0;
        if (ex >= 11'd1023) return FULL_SCALE;
        if (ex == 11'd0) return 16'd0;
        k = 1075 - int'(ex);
        if (k > 70) return 16'd0;
        prod = {75'd0, 1'b1, b[51:0]} * 128'd65535;
        prod = (prod + (128'd1 << (k - 1))) >> k;
        return prod[15:0];
    endfunction

    function automatic logic [15:0] unit_color(input logic [63:0] raw);
        case (fmt.element_type)
            ELEM_S8:  return raw[7]  ? 16'd0 : unit_from_int({56'd0, raw[7:0]}, S8_TOP);
            ELEM_U8:  return unit_from_int({56'd0, raw[7:0]}, U8_TOP);
            ELEM_S16: return raw[15] ? 16'd0 : unit_from_int({48'd0, raw[15:0]}, S16_TOP);
            ELEM_U16: return unit_from_int({48'd0, raw[15:0]}, U16_TOP);
            ELEM_S32: return raw[31] ? 16'd0 : unit_from_int({32'd0, raw[31:0]}, S32_TOP);
            ELEM_U32: return unit_from_int({32'd0, raw[31:0]}, U32_TOP);
            ELEM_F32: return unit_from_f32(raw[31:0]);
            default:  return unit_from_f64(raw);
        endcase
    endfunction

    function automatic t_out_item predict_colors(input t_in_item v);
        t_out_item   c;
        logic [63:0] span;
        logic [63:0] pos;
        span = {61'd0, fmt.component_count} + {56'd0, fmt.element_stride};
        pos  = {40'd0, v.vertex_index} * span;
        c.element_offset = pos[OFFSET_W-1:0];
        if (fmt.component_count == COUNT_RGB || fmt.component_count == COUNT_RGBA) begin
            c.red_out   = unit_color(v.raw_red);
            c.green_out = unit_color(v.raw_green);
            c.blue_out  = unit_color(v.raw_blue);
            c.alpha_out = (fmt.component_count == COUNT_RGBA) ? unit_color(v.raw_alpha)
                                                              : FULL_SCALE;
        end else begin
            c.red_out   = 16'd0;
            c.green_out = 16'd0;
            c.blue_out  = 16'd0;
            c.alpha_out = 16'd0;
        end
        return c;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("[%0t] MISMATCH on %s: got 0x%0h, expected 0x%0h (result %0d)",
                     $realtime, what, got, want, results_seen);
    endtask

    always @(posedge clk) begin : check_results
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (expected_colors.size() == 0) begin
                report_mismatch("result with nothing expected", out_data.element_offset, 0);
            end else begin
                want = expected_colors.pop_front();
                if (out_data.element_offset !== want.element_offset)
                    report_mismatch("element_offset", out_data.element_offset,
                                    want.element_offset);
                if (out_data.red_out !== want.red_out)
                    report_mismatch("red_out", out_data.red_out, want.red_out);
                if (out_data.green_out !== want.green_out)
                    report_mismatch("green_out", out_data.green_out, want.green_out);
                if (out_data.blue_out !== want.blue_out)
                    report_mismatch("blue_out", out_data.blue_out, want.blue_out);
                if (out_data.alpha_out !== want.alpha_out)
                    report_mismatch("alpha_out", out_data.alpha_out, want.alpha_out);
            end
        end
    end

    // Output back-pressure: mostly short stalls, now and then a long one.
    always @(negedge clk) begin
        if (stall_left == 0 && idle_on && $urandom_range(0, 99) < 20)
            stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(12, 40)
                                                      : $urandom_range(1, 3);
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // ---------------------------------------------------------------- driving

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Leaves valid high after the transaction so that the next vertex can follow directly.
    task automatic send_vertex(input t_in_item v);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= v;
        do @(posedge clk); while (in_stall);
        expected_colors.push_back(predict_colors(v));
        vertices_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_colors.size() != 0) @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            CFG_ELEMENT_TYPE:    fmt.element_type    = t_elem_type'(value[2:0]);
            CFG_COMPONENT_COUNT: fmt.component_count = value[2:0];
            CFG_ELEMENT_STRIDE:  fmt.element_stride  = value;
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_format(input logic [7:0] kind, input logic [7:0] count,
                              input logic [7:0] stride);
        write_register(CFG_ELEMENT_TYPE, kind);
        write_register(CFG_COMPONENT_COUNT, count);
        write_register(CFG_ELEMENT_STRIDE, stride);
    endtask

    function automatic t_in_item make_vertex(input logic [23:0] idx, input logic [63:0] r,
                                             input logic [63:0] g, input logic [63:0] b,
                                             input logic [63:0] a);
        t_in_item v;
        v.vertex_index = idx;
        v.raw_red      = r;
        v.raw_green    = g;
        v.raw_blue     = b;
        v.raw_alpha    = a;
        return v;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] float_special(input bit wide);
        case ($urandom_range(0, 7))
            0: return wide ? 64'h7FF8_0000_0000_0000 : 64'h7FC0_0000;   // NaN
            1: return wide ? 64'h8000_0000_0000_0000 : 64'h8000_0000;   // negative zero
            2: return wide ? 64'h7FF0_0000_0000_0000 : 64'h7F80_0000;   // +inf
            3: return wide ? 64'h3FF0_0000_0000_0000 : 64'h3F80_0000;   // 1.0
            4: return wide ? 64'h3FE0_0000_0000_0000 : 64'h3F00_0000;   // 0.5, a tie
            5: return wide ? 64'h0000_0000_0000_0001 : 64'h0000_0001;   // subnormal
            6: return wide ? 64'h3FEF_FFFF_FFFF_FFFF : 64'h3F7F_FFFF;   // just below 1
            default: return 64'd0;
        endcase
    endfunction

    // Raw component biased toward the interesting range of the current element type.
    function automatic logic [63:0] rand_component();
        logic [63:0] w;
        int          r;
        w = rand64();
        r = $urandom_range(0, 99);
        if (r < 30) return w;
        case (fmt.element_type)
            ELEM_F32: begin
                if (r < 42) begin
                    w[31:0] = float_special(1'b0);
                end else begin
                    w[31]    = (r < 48);
                    w[30:23] = 8'($urandom_range(105, 128));
                end
            end
            ELEM_F64: begin
                if (r < 42) begin
                    w = float_special(1'b1);
                end else begin
                    w[63]    = (r < 48);
                    w[62:52] = 11'($urandom_range(1001, 1024));
                end
            end
            ELEM_S8:  if (r < 80) w[7]  = 1'b0;
            ELEM_S16: if (r < 80) w[15] = 1'b0;
            ELEM_S32: if (r < 80) w[31] = 1'b0;
            default: ;
        endcase
        return w;
    endfunction

    function automatic logic [23:0] rand_vertex_index();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 24'hFF_FFFF;
        if (r < 20) return 24'($urandom_range(0, 15));
        return 24'($urandom);
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_reset_format();
        // Format registers as they come out of reset: unsigned bytes, four components.
        send_vertex(make_vertex(24'd0, 64'd0, 64'hFF, 64'h80, '1));
        send_vertex(make_vertex(24'hFF_FFFF, 64'h1234_5678_9ABC_DE01, 64'h7F, 64'h01, 64'hFE));
    endtask

    task automatic test_integer_limits();
        t_elem_type  kinds[6] = '{ELEM_S8, ELEM_U8, ELEM_S16, ELEM_U16, ELEM_S32, ELEM_U32};
        logic [63:0] mask;
        logic [63:0] top;
        logic [63:0] sign;
        int          w;
        bit          signed_kind;
        foreach (kinds[k]) begin
            w = (kinds[k] == ELEM_S8  || kinds[k] == ELEM_U8)  ? 8 :
                (kinds[k] == ELEM_S16 || kinds[k] == ELEM_U16) ? 16 : 32;
            signed_kind = (kinds[k] == ELEM_S8 || kinds[k] == ELEM_S16 || kinds[k] == ELEM_S32);
            mask = (64'd1 << w) - 1;
            top  = signed_kind ? (mask >> 1) : mask;
            sign = 64'd1 << (w - 1);
            set_format({5'd0, kinds[k]}, {5'd0, COUNT_RGBA}, 8'(k * 51));
            // Zero, the type maximum with junk above it, the sign bit alone, all ones.
            send_vertex(make_vertex(24'($urandom), 64'd0,
                                    top | (64'hC3C3_C3C3_C3C3_C3C3 & ~mask), sign, '1));
        end
    endtask

    task automatic test_float_specials();
        set_format({5'd0, ELEM_F32}, {5'd0, COUNT_RGBA}, 8'd0);
        send_vertex(make_vertex(24'd1, 64'h7FC0_0000, 64'h8000_0000, 64'h7F80_0000,
                                64'h3F80_0000));
        send_vertex(make_vertex(24'd2, 64'h3F00_0000, 64'h3F7F_FFFF, 64'h0000_0001,
                                64'hFF80_0000));
        // Smallest exponent that the block still computes, one below it, junk in the upper word.
        send_vertex(make_vertex(24'd3, 64'h3680_0000, 64'h3600_0000,
                                64'hDEAD_BEEF_3F00_0000, 64'h7F80_0001));

        set_format({5'd0, ELEM_F64}, {5'd0, COUNT_RGBA}, 8'd3);
        send_vertex(make_vertex(24'd4, 64'h7FF8_0000_0000_0000, 64'h8000_0000_0000_0000,
                                64'h7FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000));
        send_vertex(make_vertex(24'd5, 64'h3FE0_0000_0000_0000, 64'h3FEF_FFFF_FFFF_FFFF,
                                64'h0000_0000_0000_0001, 64'hFFF0_0000_0000_0000));
        send_vertex(make_vertex(24'd6, 64'h3ED0_0000_0000_0000, 64'h3EC0_0000_0000_0000,
                                64'h3FD5_5555_5555_5555, 64'h7FF0_0000_0000_0001));
    endtask

    task automatic test_component_counts();
        logic [2:0] dull_counts[6] = '{3'd0, 3'd1, 3'd2, 3'd5, 3'd6, 3'd7};
        // With three components alpha is fixed at full scale whatever the raw word says.
        set_format({5'd0, ELEM_U16}, {5'd0, COUNT_RGB}, 8'd1);
        send_vertex(make_vertex(24'hFF_FFFF, 64'hFFFF, 64'h8000, 64'h0001, 64'd0));
        // Junk above the low three bits of the count, then a write to the unused index.
        set_format({5'b10110, ELEM_U8}, {5'b10101, COUNT_RGBA}, 8'd255);
        write_register(CFG_UNUSED_INDEX, 8'hFF);
        send_vertex(make_vertex(24'hFF_FFFF, 64'h80, 64'hFF, 64'h01, 64'h7F));
        foreach (dull_counts[k]) begin
            write_register(CFG_COMPONENT_COUNT, {5'd0, dull_counts[k]});
            send_vertex(make_vertex(24'hFF_FFFF - 24'(k), '1, '1, '1, '1));
        end
    endtask

    task automatic test_random_formats();
        t_elem_type kinds[8] = '{ELEM_S8, ELEM_U8, ELEM_S16, ELEM_U16,
                                 ELEM_S32, ELEM_U32, ELEM_F32, ELEM_F64};
        logic [2:0] count;
        logic [7:0] stride;
        int         r;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            r = $urandom_range(0, 99);
            count = (r < 45) ? COUNT_RGBA : (r < 80) ? COUNT_RGB : 3'($urandom_range(0, 7));
            r = $urandom_range(0, 99);
            stride = (r < 30) ? 8'd0 : (r < 45) ? 8'd255 : 8'($urandom);
            set_format({5'($urandom), kinds[p % 8]}, {5'($urandom), count}, stride);
            // One phase in five runs without any idling on either side.
            idle_on = (p % 5 != 3);
            for (int n = 0; n < PHASE_VERTS; n++) begin
                // Halfway through one phase the sender holds off until the pipe is empty.
                if (p == RANDOM_PHASES / 2 && n == PHASE_VERTS / 2)
                    wait_idle();
                send_vertex(make_vertex(rand_vertex_index(), rand_component(),
                                        rand_component(), rand_component(),
                                        rand_component()));
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        fmt.element_type    = RST_ELEMENT_TYPE;
        fmt.component_count = RST_COMPONENT_COUNT;
        fmt.element_stride  = RST_ELEMENT_STRIDE;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_format();
        test_integer_limits();
        test_float_specials();
        test_component_counts();
        test_random_formats();

        wait_idle();
        repeat (PIPE_LATENCY + 4) @(posedge clk);
        if (expected_colors.size() != 0)
            report_mismatch("results never delivered", expected_colors.size(), 0);

        $display("Sent %0d vertices across %0d register writes and checked %0d colored results,",
                 vertices_sent, reg_writes, results_seen);
        $display("covering all eight element types, component counts 0 to 7 and strides 0 to 255.");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", errors);
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
hw/rtl/cafn_pkg.sv
hw/rtl/cafn_cfg.sv
hw/rtl/cafn_norm.sv
hw/rtl/color_attribute_fetch_normalize.sv
tb/tb_top.sv
